### src/rec_pkg.sv
package rec_pkg;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FINISH = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic [31:0] TOP_VALUE  = 32'h0100_0000;
  localparam logic [31:0] EMIT_LIMIT = 32'hFF00_0000;
  localparam logic [31:0] RANGE_INIT = 32'hFFFF_FFFF;
  localparam int unsigned FINISH_SHIFTS = 5;
  localparam int unsigned ENCODE_SHIFTS = 4;

  typedef struct packed {
    op_t         op;
    logic [15:0] cum;
    logic [15:0] sym;
    logic [15:0] tot;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_LOW,
    ST_DIV_RANGE,
    ST_SHIFT,
    ST_EMIT
  } state_t;

endpackage

### src/rec_front.sv
module rec_front #(
  parameter int FREQ_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          valid,
  output logic          stall,
  input  logic [1:0]    opcode,
  input  logic [15:0]   cum_freq,
  input  logic [15:0]   sym_freq,
  input  logic [15:0]   total_freq,
  output logic          q_valid,
  input  logic          q_pop,
  output rec_pkg::cmd_t q_cmd
);

  localparam logic [15:0] MASK = 16'((32'd1 << FREQ_BITS) - 1);

  rec_pkg::cmd_t entry [2];
  logic [0:0] wr_ptr;
  logic [0:0] rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       useful;
  rec_pkg::cmd_t cmd_in;

  always_comb begin
    cmd_in.op  = rec_pkg::op_t'(opcode);
    cmd_in.cum = cum_freq & MASK;
    cmd_in.sym = sym_freq & MASK;
    cmd_in.tot = total_freq & MASK;
    useful = (cmd_in.op == rec_pkg::OP_START) || (cmd_in.op == rec_pkg::OP_FINISH) ||
             ((cmd_in.op == rec_pkg::OP_ENCODE) && (cmd_in.tot != 16'd0));
  end

  assign stall   = (count == 2'd2);
  assign push    = valid && !stall && useful;
  assign q_valid = (count != 2'd0);
  assign q_cmd   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

### src/rec_div.sv
module rec_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [47:0] quotient
);

  logic [47:0] quo;
  logic [15:0] rem;
  logic [15:0] dsr;
  logic [5:0]  cnt;
  logic        busy;
  logic [16:0] trial;
  logic [16:0] diff;

  always_comb begin
    trial = {rem, quo[47]};
    diff  = trial - {1'b0, dsr};
  end

  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= 16'd0;
      dsr <= divisor;
    end else if (busy) begin
      if (!diff[16]) begin
        rem <= diff[15:0];
        quo <= {quo[46:0], 1'b1};
      end else begin
        rem <= trial[15:0];
        quo <= {quo[46:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 6'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### src/rec_back.sv
module rec_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_pop,
  input  rec_pkg::cmd_t q_cmd,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    lead_byte,
  output logic [7:0]    fill_byte,
  output logic [31:0]   fill_count,
  output logic          last
);

  rec_pkg::state_t state;
  rec_pkg::state_t state_next;

  logic [31:0] range_reg;
  logic [31:0] low_reg;
  logic        carry_bit;
  logic [7:0]  cache_byte;
  logic [31:0] pending_count;
  logic [2:0]  shifts;
  logic [2:0]  shift_max;
  logic        is_finish;
  rec_pkg::cmd_t cmd;

  logic        div_start;
  logic [47:0] div_dividend;
  logic [15:0] div_divisor;
  logic        div_done;
  logic [47:0] div_q;
  logic [32:0] low_sum;
  logic        emit;
  logic        more;
  logic        out_free;
  logic [63:0] low_ext;
  logic [63:0] rng_ext;
  logic        alive;
  logic        later_emit;

  rec_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign low_sum  = {1'b0, low_reg} + {1'b0, div_q[31:0]};
  assign emit     = (low_reg < rec_pkg::EMIT_LIMIT) || carry_bit;
  assign out_free = !out_valid || !out_stall;
  // another shift follows this one
  assign more     = is_finish ? (shifts + 3'd1 < shift_max)
                              : ((shifts + 3'd1 < shift_max) &&
                                 ({range_reg[23:0], 8'd0} < rec_pkg::TOP_VALUE));

  // a later shift of this item emits (carry is clear after an emit)
  always_comb begin
    low_ext    = {low_reg, 32'd0};
    rng_ext    = {range_reg, 32'd0};
    alive      = 1'b1;
    later_emit = 1'b0;
    for (int j = 1; j < 5; j++) begin
      alive = alive && ((4'(shifts) + 4'(j)) < {1'b0, shift_max}) &&
              (is_finish || (rng_ext[63 - 8*j -: 8] == 8'd0));
      if (alive && (low_ext[63 - 8*j -: 8] != 8'hFF)) begin
        later_emit = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rec_pkg::ST_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            rec_pkg::OP_ENCODE: state_next = rec_pkg::ST_DIV_LOW;
            rec_pkg::OP_FINISH: state_next = rec_pkg::ST_SHIFT;
            default:            state_next = rec_pkg::ST_IDLE;
          endcase
        end
      end
      rec_pkg::ST_DIV_LOW: begin
        if (div_done) begin
          state_next = rec_pkg::ST_DIV_RANGE;
        end
      end
      rec_pkg::ST_DIV_RANGE: begin
        if (div_done) begin
          state_next = rec_pkg::ST_SHIFT;
        end
      end
      rec_pkg::ST_SHIFT: begin
        if (!is_finish && ((range_reg >= rec_pkg::TOP_VALUE) || (shifts == shift_max))) begin
          state_next = rec_pkg::ST_IDLE;
        end else if (emit) begin
          state_next = rec_pkg::ST_EMIT;
        end else if (!more) begin
          state_next = rec_pkg::ST_IDLE;
        end
      end
      rec_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = more ? rec_pkg::ST_SHIFT : rec_pkg::ST_IDLE;
        end
      end
      default: state_next = rec_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = (state == rec_pkg::ST_IDLE) && q_valid;
    div_start    = 1'b0;
    div_dividend = {16'd0, range_reg} * 48'(q_cmd.cum);
    div_divisor  = cmd.tot;
    if (state == rec_pkg::ST_IDLE && q_valid && q_cmd.op == rec_pkg::OP_ENCODE) begin
      div_start    = 1'b1;
      div_dividend = 48'({range_reg, 16'd0} >> 16) * 48'(q_cmd.cum);
      div_divisor  = q_cmd.tot;
    end else if (state == rec_pkg::ST_DIV_LOW && div_done) begin
      div_start    = 1'b1;
      div_dividend = 48'(range_reg) * 48'(cmd.sym);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rec_pkg::ST_IDLE;
      range_reg     <= rec_pkg::RANGE_INIT;
      low_reg       <= 32'd0;
      carry_bit     <= 1'b0;
      cache_byte    <= 8'd0;
      pending_count <= 32'd0;
      shifts        <= 3'd0;
      shift_max     <= 3'd0;
      is_finish     <= 1'b0;
      out_valid     <= 1'b0;
      lead_byte     <= 8'd0;
      fill_byte     <= 8'd0;
      fill_count    <= 32'd0;
      last          <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        rec_pkg::ST_IDLE: begin
          shifts <= 3'd0;
          if (q_valid) begin
            is_finish <= (q_cmd.op == rec_pkg::OP_FINISH);
            shift_max <= (q_cmd.op == rec_pkg::OP_FINISH) ? 3'(rec_pkg::FINISH_SHIFTS)
                                                          : 3'(rec_pkg::ENCODE_SHIFTS);
            if (q_cmd.op == rec_pkg::OP_START) begin
              range_reg     <= rec_pkg::RANGE_INIT;
              low_reg       <= 32'd0;
              carry_bit     <= 1'b0;
              pending_count <= 32'd0;
            end
          end
        end
        rec_pkg::ST_DIV_LOW: begin
          if (div_done) begin
            low_reg <= low_sum[31:0];
            if (low_sum[32]) begin
              carry_bit <= 1'b1;
            end
          end
        end
        rec_pkg::ST_DIV_RANGE: begin
          if (div_done) begin
            range_reg <= (div_q[47:32] != 16'd0) ? rec_pkg::RANGE_INIT : div_q[31:0];
          end
        end
        rec_pkg::ST_SHIFT: begin
          if (is_finish || ((range_reg < rec_pkg::TOP_VALUE) && (shifts != shift_max))) begin
            if (!emit) begin
              if (!is_finish) begin
                range_reg <= {range_reg[23:0], 8'd0};
              end
              pending_count <= pending_count + 32'd1;
              low_reg       <= {low_reg[23:0], 8'd0};
              shifts        <= shifts + 3'd1;
            end
          end
        end
        rec_pkg::ST_EMIT: begin
          if (out_free) begin
            if (!is_finish) begin
              range_reg <= {range_reg[23:0], 8'd0};
            end
            out_valid     <= 1'b1;
            lead_byte     <= cache_byte + {7'd0, carry_bit};
            fill_byte     <= carry_bit ? 8'h00 : 8'hFF;
            fill_count    <= pending_count;
            last          <= !later_emit;
            pending_count <= 32'd0;
            cache_byte    <= low_reg[31:24];
            carry_bit     <= 1'b0;
            low_reg       <= {low_reg[23:0], 8'd0};
            shifts        <= shifts + 3'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### src/range_encoder_carry_cache.sv
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | opcode cum_freq sym_freq total_freq
// out     | output    | out_valid/out_stall| lead_byte fill_byte fill_count last
// Encode: two 48-bit quotients from the shared bit-serial divider, then
// the shifts. Finish runs only the shifts; start resets the coder state.
// A two-entry queue decouples input.
// Reset clears the coder state and the cache byte; output stall holds the
// result register and pauses any shift that emits a byte.
module range_encoder_carry_cache #(
  parameter int FREQ_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [15:0] cum_freq,
  input  logic [15:0] sym_freq,
  input  logic [15:0] total_freq,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  lead_byte,
  output logic [7:0]  fill_byte,
  output logic [31:0] fill_count,
  output logic        last
);

  logic          q_valid;
  logic          q_pop;
  rec_pkg::cmd_t q_cmd;

  rec_front #(.FREQ_BITS(FREQ_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .valid      (in_valid),
    .stall      (in_stall),
    .opcode     (opcode),
    .cum_freq   (cum_freq),
    .sym_freq   (sym_freq),
    .total_freq (total_freq),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_cmd      (q_cmd)
  );

  rec_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_cmd      (q_cmd),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .lead_byte  (lead_byte),
    .fill_byte  (fill_byte),
    .fill_count (fill_count),
    .last       (last)
  );

endmodule

### src/rec_check.sv
module rec_check (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  lead_byte,
  input logic [7:0]  fill_byte,
  input logic [31:0] fill_count,
  input logic        last
);

  a_fill_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fill_byte == 8'hFF || fill_byte == 8'h00))
    else $error("fill byte not 0x00 or 0xFF");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(lead_byte) && $stable(fill_count)
      && $stable(last))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind range_encoder_carry_cache rec_check u_rec_check (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .lead_byte  (lead_byte),
  .fill_byte  (fill_byte),
  .fill_count (fill_count),
  .last       (last)
);
